/* rtl/dhd_pkg.sv */
// Shared types and constants for the datagram header deframer.
package dhd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA      = 2'd0;
    localparam logic [1:0] KIND_EMPTY     = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN   = 2'd2;
    localparam logic [1:0] KIND_BAD_DIGIT = 2'd3;

    // Configuration register indexes
    localparam logic CFG_ASCII_CODE  = 1'b0;
    localparam logic CFG_BINARY_CODE = 1'b1;

    // Reset values of the type codes
    localparam logic [7:0] ASCII_CODE_RESET  = 8'd65;
    localparam logic [7:0] BINARY_CODE_RESET = 8'd66;

    // Frame type values
    localparam logic FT_ASCII  = 1'b0;
    localparam logic FT_BINARY = 1'b1;

    // One result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic        frame_type;
        logic [7:0]  payload_byte;
        logic [15:0] frame_length;
        logic        is_last;
    } result_t;

    // Configured type codes.
    typedef struct packed {
        logic [7:0] ascii_code;
        logic [7:0] binary_code;
    } type_codes_t;

endpackage

/* rtl/dhd_cfg_regs.sv */
// Configuration registers holding the two datagram type codes.
module dhd_cfg_regs (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_addr,
    input  logic [7:0]           cfg_wr_data,
    output dhd_pkg::type_codes_t codes
);

    logic [7:0] ascii_code_reg;
    logic [7:0] binary_code_reg;

    // Register writes, decoded by index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ascii_code_reg  <= dhd_pkg::ASCII_CODE_RESET;
            binary_code_reg <= dhd_pkg::BINARY_CODE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                dhd_pkg::CFG_ASCII_CODE:  ascii_code_reg  <= cfg_wr_data;
                dhd_pkg::CFG_BINARY_CODE: binary_code_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign codes.ascii_code  = ascii_code_reg;
    assign codes.binary_code = binary_code_reg;

endmodule

/* rtl/dhd_parser.sv */
// Frame parser: header decoding state and result generation for one byte.
module dhd_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_accept,
    input  logic [7:0]           byte_in,
    input  dhd_pkg::type_codes_t codes,
    output logic                 res_push,
    output dhd_pkg::result_t     res
);

    localparam logic [1:0] PH_TYPE = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    logic [1:0]  phase_reg,        phase_next;
    logic        is_binary_reg,    is_binary_next;
    logic [15:0] length_acc_reg,   length_acc_next;
    logic [2:0]  header_count_reg, header_count_next;
    logic [15:0] bytes_left_reg,   bytes_left_next;

    logic [7:0]  digit;
    logic [15:0] acc_times_ten;
    logic        header_done;
    logic        push;

    // The length digit and the accumulator scaled by ten as two shifted adds.
    assign digit         = byte_in - 8'h30;
    assign acc_times_ten = {length_acc_reg[12:0], 3'b000} + {length_acc_reg[14:0], 1'b0};

    // Next state and result for the byte presented.
    always_comb begin
        phase_next        = phase_reg;
        is_binary_next    = is_binary_reg;
        length_acc_next   = length_acc_reg;
        header_count_next = header_count_reg;
        bytes_left_next   = bytes_left_reg;
        header_done       = 1'b0;
        push              = 1'b0;
        res               = '0;
        case (phase_reg)
            PH_LEN: begin
                if (is_binary_reg) begin
                    length_acc_next   = {length_acc_reg[7:0], byte_in};
                    header_count_next = header_count_reg + 3'd1;
                    header_done       = (header_count_next >= 3'd2);
                end else if (digit > 8'd9) begin
                    // Not a decimal digit: report it and drop the frame.
                    push             = 1'b1;
                    res.kind         = dhd_pkg::KIND_BAD_DIGIT;
                    res.frame_type   = dhd_pkg::FT_ASCII;
                    res.payload_byte = byte_in;
                    res.frame_length = length_acc_reg;
                    res.is_last      = 1'b1;
                    phase_next       = PH_TYPE;
                end else begin
                    length_acc_next   = acc_times_ten + {8'd0, digit};
                    header_count_next = header_count_reg + 3'd1;
                    header_done       = (header_count_next >= 3'd4);
                end
                if (header_done) begin
                    if (length_acc_next == 16'd0) begin
                        push           = 1'b1;
                        res.kind       = dhd_pkg::KIND_EMPTY;
                        res.frame_type = is_binary_reg;
                        res.is_last    = 1'b1;
                        phase_next     = PH_TYPE;
                    end else begin
                        bytes_left_next = length_acc_next;
                        phase_next      = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                push             = 1'b1;
                res.kind         = dhd_pkg::KIND_DATA;
                res.frame_type   = is_binary_reg;
                res.payload_byte = byte_in;
                res.frame_length = length_acc_reg;
                res.is_last      = (bytes_left_reg <= 16'd1);
                bytes_left_next  = bytes_left_reg - 16'd1;
                if (res.is_last) begin
                    phase_next = PH_TYPE;
                end
            end
            default: begin
                // Waiting for a type byte; the ASCII code wins when both match.
                if (byte_in == codes.ascii_code || byte_in == codes.binary_code) begin
                    is_binary_next    = (byte_in != codes.ascii_code);
                    length_acc_next   = 16'd0;
                    header_count_next = 3'd0;
                    bytes_left_next   = 16'd0;
                    phase_next        = PH_LEN;
                end else begin
                    push             = 1'b1;
                    res.kind         = dhd_pkg::KIND_UNKNOWN;
                    res.frame_type   = dhd_pkg::FT_ASCII;
                    res.payload_byte = byte_in;
                    res.is_last      = 1'b1;
                    phase_next       = PH_TYPE;
                end
            end
        endcase
    end

    assign res_push = byte_accept & push;

    // State update on each accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_TYPE;
            is_binary_reg    <= 1'b0;
            length_acc_reg   <= 16'd0;
            header_count_reg <= 3'd0;
            bytes_left_reg   <= 16'd0;
        end else if (byte_accept) begin
            phase_reg        <= phase_next;
            is_binary_reg    <= is_binary_next;
            length_acc_reg   <= length_acc_next;
            header_count_reg <= header_count_next;
            bytes_left_reg   <= bytes_left_next;
        end
    end

endmodule

/* rtl/dhd_out_stage.sv */
// Result register with a skid entry, so input transfers continue while a result waits.
module dhd_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_push,
    input  dhd_pkg::result_t res_in,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output dhd_pkg::result_t res_out
);

    logic             main_valid_reg;
    logic             skid_valid_reg;
    dhd_pkg::result_t main_reg;
    dhd_pkg::result_t skid_reg;
    logic             main_free;

    assign main_free = !main_valid_reg || out_ready;
    assign in_ready  = !skid_valid_reg;

    // Valid flags of the two entries.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_free) begin
            main_valid_reg <= skid_valid_reg || res_push;
            skid_valid_reg <= 1'b0;
        end else if (res_push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Result payloads.
    always_ff @(posedge aclk) begin
        if (main_free) begin
            main_reg <= skid_valid_reg ? skid_reg : res_in;
        end else if (res_push) begin
            skid_reg <= res_in;
        end
    end

    assign out_valid = main_valid_reg;
    assign res_out   = main_reg;

endmodule

/* rtl/datagram_header_deframer.sv */
// Each result is registered in the result stage and offered on the m_ channel from there.
// Throughput: one byte per cycle while s_ready is high; bytes are decoded combinationally.
// A two-entry result stage lets byte transfers continue while one result waits.
// Reset (aresetn low, synchronous) clears the parser to wait for a type byte,
// empties the result stage and loads the type codes with 65 (ASCII) and 66 (binary).
module datagram_header_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic        m_frame_type,
    output logic [7:0]  m_payload_byte,
    output logic [15:0] m_frame_length,
    output logic        m_is_last
);

    dhd_pkg::type_codes_t codes;
    dhd_pkg::result_t     res;
    dhd_pkg::result_t     res_out;
    logic                 res_push;
    logic                 byte_accept;

    assign byte_accept = s_valid && s_ready;

    // Type code registers.
    dhd_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .codes       (codes)
    );

    // Header parser.
    dhd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .byte_in     (s_byte_in),
        .codes       (codes),
        .res_push    (res_push),
        .res         (res)
    );

    // Result stage.
    dhd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_push  (res_push),
        .res_in    (res),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .res_out   (res_out)
    );

    assign m_kind         = res_out.kind;
    assign m_frame_type   = res_out.frame_type;
    assign m_payload_byte = res_out.payload_byte;
    assign m_frame_length = res_out.frame_length;
    assign m_is_last      = res_out.is_last;

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the datagram header deframer: directed, configuration and random tests.
`timescale 1ns / 1ps

module tb_top;

    localparam int          RX_HOLD_CYCLES = 300;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          STALL_LIMIT    = 2000;
    localparam int          CHUNK_BYTES    = 80;
    localparam int          RANDOM_CHUNKS  = 6;
    localparam logic [7:0]  CHAR_ZERO      = 8'h30;

    typedef enum logic [1:0] {
        PH_WAIT_TYPE,
        PH_READ_LENGTH,
        PH_READ_PAYLOAD
    } parse_phase_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [7:0]  cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_byte_in;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_kind;
    logic        m_frame_type;
    logic [7:0]  m_payload_byte;
    logic [15:0] m_frame_length;
    logic        m_is_last;

    // Deframer model state and the type codes it matches against.
    parse_phase_t prs_phase;
    logic         prs_binary;
    logic [15:0]  prs_len_acc;
    logic [2:0]   prs_hdr_count;
    logic [15:0]  prs_remaining;
    logic [7:0]   codes_ascii;
    logic [7:0]   codes_binary;

    // Results still owed by the block, oldest first.
    dhd_pkg::result_t pending[$];

    bit           tx_no_gaps   = 1'b0;
    bit           rx_no_stalls = 1'b0;
    bit           rx_hold_req  = 1'b0;
    int           bytes_sent   = 0;
    int           results_seen = 0;
    int           code_writes  = 0;
    int           mismatches   = 0;
    int           idle_cycles  = 0;
    int           kind_count[4];

    datagram_header_deframer DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_byte_in      (s_byte_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_frame_type   (m_frame_type),
        .m_payload_byte (m_payload_byte),
        .m_frame_length (m_frame_length),
        .m_is_last      (m_is_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Advance the deframer model by one byte and queue the result it gives, if any.
    task automatic predict_byte(input logic [7:0] value);
        dhd_pkg::result_t res;
        logic [7:0]       digit;
        logic             emit;
        logic             header_done;
        res         = '0;
        emit        = 1'b0;
        header_done = 1'b0;
        case (prs_phase)
            PH_READ_LENGTH: begin
                if (prs_binary) begin
                    prs_len_acc   = {prs_len_acc[7:0], value};
                    prs_hdr_count = prs_hdr_count + 3'd1;
                    header_done   = (prs_hdr_count >= 3'd2);
                end else begin
                    digit = value - CHAR_ZERO;
                    if (digit > 8'd9) begin
                        // A non-digit drops the frame and reports the digits so far.
                        emit             = 1'b1;
                        res.kind         = dhd_pkg::KIND_BAD_DIGIT;
                        res.frame_type   = dhd_pkg::FT_ASCII;
                        res.payload_byte = value;
                        res.frame_length = prs_len_acc;
                        res.is_last      = 1'b1;
                        prs_phase        = PH_WAIT_TYPE;
                    end else begin
                        prs_len_acc   = prs_len_acc * 16'd10 + {8'd0, digit};
                        prs_hdr_count = prs_hdr_count + 3'd1;
                        header_done   = (prs_hdr_count >= 3'd4);
                    end
                end
                if (header_done) begin
                    if (prs_len_acc == 16'd0) begin
                        emit             = 1'b1;
                        res.kind         = dhd_pkg::KIND_EMPTY;
                        res.frame_type   = prs_binary;
                        res.payload_byte = 8'd0;
                        res.frame_length = 16'd0;
                        res.is_last      = 1'b1;
                        prs_phase        = PH_WAIT_TYPE;
                    end else begin
                        prs_remaining = prs_len_acc;
                        prs_phase     = PH_READ_PAYLOAD;
                    end
                end
            end
            PH_READ_PAYLOAD: begin
                emit             = 1'b1;
                res.kind         = dhd_pkg::KIND_DATA;
                res.frame_type   = prs_binary;
                res.payload_byte = value;
                res.frame_length = prs_len_acc;
                res.is_last      = (prs_remaining <= 16'd1);
                prs_remaining    = prs_remaining - 16'd1;
                if (res.is_last) begin
                    prs_phase = PH_WAIT_TYPE;
                end
            end
            default: begin
                // The ASCII code wins when both codes are equal.
                if (value == codes_ascii || value == codes_binary) begin
                    prs_binary    = (value != codes_ascii);
                    prs_len_acc   = 16'd0;
                    prs_hdr_count = 3'd0;
                    prs_remaining = 16'd0;
                    prs_phase     = PH_READ_LENGTH;
                end else begin
                    emit             = 1'b1;
                    res.kind         = dhd_pkg::KIND_UNKNOWN;
                    res.frame_type   = dhd_pkg::FT_ASCII;
                    res.payload_byte = value;
                    res.frame_length = 16'd0;
                    res.is_last      = 1'b1;
                    prs_phase        = PH_WAIT_TYPE;
                end
            end
        endcase
        if (emit) begin
            pending.push_back(res);
        end
    endtask

    // Offer one byte after a random gap and wait for its transfer.
    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 11);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_byte_in <= value;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        predict_byte(value);
        bytes_sent++;
    endtask

    // Stop offering and wait until every owed result has been taken.
    task automatic drain_results();
        @(negedge aclk) s_valid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Program one type code; only called while the block is idle.
    task automatic write_code(input logic index, input logic [7:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= index;
        cfg_wr_data <= value;
        @(negedge aclk) cfg_wr_en <= 1'b0;
        if (index == dhd_pkg::CFG_ASCII_CODE) begin
            codes_ascii = value;
        end else begin
            codes_binary = value;
        end
        code_writes++;
    endtask

    task automatic send_ascii_header(input int unsigned len);
        int unsigned d;
        send_byte(codes_ascii);
        d = (len / 1000) % 10;
        send_byte(CHAR_ZERO + d[7:0]);
        d = (len / 100) % 10;
        send_byte(CHAR_ZERO + d[7:0]);
        d = (len / 10) % 10;
        send_byte(CHAR_ZERO + d[7:0]);
        d = len % 10;
        send_byte(CHAR_ZERO + d[7:0]);
    endtask

    task automatic send_binary_header(input logic [15:0] len);
        send_byte(codes_binary);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    task automatic send_payload(input int unsigned len);
        repeat (len) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_ascii_frame(input int unsigned len);
        send_ascii_header(len);
        send_payload(len);
    endtask

    task automatic send_binary_frame(input int unsigned len);
        send_binary_header(len[15:0]);
        send_payload(len);
    endtask

    // ASCII header cut short by a non-digit after up to three good digits.
    task automatic send_broken_length();
        int unsigned bad;
        send_byte(codes_ascii);
        repeat ($urandom_range(0, 3)) send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
        do begin
            bad = $urandom_range(0, 255);
        end while (bad >= CHAR_ZERO && bad <= CHAR_ZERO + 9);
        send_byte(bad[7:0]);
    endtask

    task automatic send_unknown_type();
        int unsigned b;
        do begin
            b = $urandom_range(0, 255);
        end while (b == codes_ascii || b == codes_binary);
        send_byte(b[7:0]);
    endtask

    // Mostly short frames, some empty, a few of several dozen bytes.
    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return 0;
        end else if (r < 17) begin
            return $urandom_range(1, 8);
        end
        return $urandom_range(9, 48);
    endfunction

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] %s: expected %0d, actual %0d", $realtime, what, want, got);
        end
    endtask

    // Drive the result ready with random stalls, or a long hold when asked.
    initial begin : result_receiver
        int stall;
        m_ready = 1'b0;
        forever begin
            stall = rx_no_stalls ? 0 : $urandom_range(0, 11);
            if (rx_hold_req) begin
                stall       = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (stall > 0) begin
                @(negedge aclk) m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk) m_ready <= 1'b1;
            @(posedge aclk);
            while (!aresetn || m_valid !== 1'b1) @(posedge aclk);
        end
    end

    // Compare each result transfer with the oldest owed result.
    always @(posedge aclk) begin : result_checker
        dhd_pkg::result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            results_seen++;
            kind_count[m_kind]++;
            if (pending.size() == 0) begin
                note_mismatch("result with nothing owed, kind", 0, 32'(m_kind));
            end else begin
                want = pending.pop_front();
                if (m_kind !== want.kind)
                    note_mismatch("kind", 32'(want.kind), 32'(m_kind));
                if (m_frame_type !== want.frame_type)
                    note_mismatch("frame_type", 32'(want.frame_type), 32'(m_frame_type));
                if (m_payload_byte !== want.payload_byte)
                    note_mismatch("payload_byte", 32'(want.payload_byte),
                                  32'(m_payload_byte));
                if (m_frame_length !== want.frame_length)
                    note_mismatch("frame_length", 32'(want.frame_length),
                                  32'(m_frame_length));
                if (m_is_last !== want.is_last)
                    note_mismatch("is_last", 32'(want.is_last), 32'(m_is_last));
            end
        end
    end

    // End the run if no transfer happens on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles without a transfer", STALL_LIMIT);
            $display("datagram_header_deframer verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Extremes of payload and length, both empty frames, unknown type, bad digits.
    task automatic test_directed();
        send_ascii_header(2);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_binary_header(16'd1);
        send_byte(8'h5A);
        send_binary_header(16'd0);
        send_ascii_header(0);
        send_byte(8'hFF);
        // Digit just below '0' after one good digit, then just above '9' at once.
        send_byte(codes_ascii);
        send_byte(CHAR_ZERO + 8'd1);
        send_byte(CHAR_ZERO - 8'd1);
        send_byte(codes_ascii);
        send_byte(CHAR_ZERO + 8'd10);
        drain_results();
    endtask

    // Type codes at their extremes, swapped, and equal to each other.
    task automatic test_type_codes();
        write_code(dhd_pkg::CFG_ASCII_CODE, 8'd0);
        write_code(dhd_pkg::CFG_BINARY_CODE, 8'd255);
        send_ascii_frame(3);
        send_binary_frame(2);
        send_byte(dhd_pkg::ASCII_CODE_RESET);
        send_broken_length();
        drain_results();

        write_code(dhd_pkg::CFG_ASCII_CODE, 8'd255);
        write_code(dhd_pkg::CFG_BINARY_CODE, 8'd0);
        send_ascii_frame(2);
        send_binary_frame(4);
        send_binary_header(16'd0);
        send_unknown_type();
        drain_results();

        // With equal codes the binary header reads as ASCII and breaks on its length.
        write_code(dhd_pkg::CFG_ASCII_CODE, 8'h7E);
        write_code(dhd_pkg::CFG_BINARY_CODE, 8'h7E);
        send_ascii_frame(2);
        send_binary_header(16'd3);
        send_ascii_frame(0);
        drain_results();

        write_code(dhd_pkg::CFG_ASCII_CODE, dhd_pkg::ASCII_CODE_RESET);
        write_code(dhd_pkg::CFG_BINARY_CODE, dhd_pkg::BINARY_CODE_RESET);
    endtask

    // Receiver holds off while bytes keep coming, so the input must stall.
    task automatic test_result_backpressure();
        rx_hold_req = 1'b1;
        tx_no_gaps  = 1'b1;
        send_binary_frame(48);
        tx_no_gaps  = 1'b0;
        drain_results();
        send_ascii_frame(5);
        send_unknown_type();
        drain_results();
    endtask

    // One long binary frame that needs both length bytes, streamed without idling.
    task automatic test_long_frame();
        tx_no_gaps   = 1'b1;
        rx_no_stalls = 1'b1;
        send_binary_frame(16'h0105);
        drain_results();
        tx_no_gaps   = 1'b0;
        rx_no_stalls = 1'b0;
    endtask

    // Chunks of random traffic, each with fresh type codes and idling mode.
    task automatic test_random_stream();
        int unsigned target;
        int unsigned pick;
        int unsigned code_a;
        int unsigned code_b;
        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
            code_a = $urandom_range(0, 255);
            do begin
                code_b = $urandom_range(0, 255);
            end while (code_b == code_a);
            write_code(dhd_pkg::CFG_ASCII_CODE, code_a[7:0]);
            write_code(dhd_pkg::CFG_BINARY_CODE, code_b[7:0]);
            pick         = $urandom_range(0, 3);
            tx_no_gaps   = (pick == 0 || pick == 1);
            rx_no_stalls = (pick == 0 || pick == 2);
            target = bytes_sent + CHUNK_BYTES;
            while (bytes_sent < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    send_ascii_frame(pick_length());
                end else if (pick < 75) begin
                    send_binary_frame(pick_length());
                end else if (pick < 85) begin
                    send_broken_length();
                end else if (pick < 95) begin
                    send_unknown_type();
                end else begin
                    send_byte(8'($urandom_range(0, 255)));
                end
            end
            drain_results();
        end
        tx_no_gaps   = 1'b0;
        rx_no_stalls = 1'b0;
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = dhd_pkg::CFG_ASCII_CODE;
        cfg_wr_data   = 8'd0;
        s_valid       = 1'b0;
        s_byte_in     = 8'd0;
        codes_ascii   = dhd_pkg::ASCII_CODE_RESET;
        codes_binary  = dhd_pkg::BINARY_CODE_RESET;
        prs_phase     = PH_WAIT_TYPE;
        prs_binary    = 1'b0;
        prs_len_acc   = 16'd0;
        prs_hdr_count = 3'd0;
        prs_remaining = 16'd0;
        foreach (kind_count[k]) kind_count[k] = 0;

        repeat (6) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        test_directed();
        test_type_codes();
        test_result_backpressure();
        test_long_frame();
        test_random_stream();

        drain_results();
        if (pending.size() != 0) begin
            note_mismatch("results never delivered", 0, 32'(pending.size()));
        end

        $display("Run covered %0d byte transfers and %0d results (%0d payload, %0d empty,",
                 bytes_sent, results_seen, kind_count[dhd_pkg::KIND_DATA],
                 kind_count[dhd_pkg::KIND_EMPTY]);
        $display("%0d unknown type, %0d bad digit) over %0d type code writes; %0d mismatches.",
                 kind_count[dhd_pkg::KIND_UNKNOWN], kind_count[dhd_pkg::KIND_BAD_DIGIT],
                 code_writes, mismatches);
        if (mismatches == 0) begin
            $display("datagram_header_deframer verification clean");
        end else begin
            $display("datagram_header_deframer verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/dhd_pkg.sv
rtl/dhd_cfg_regs.sv
rtl/dhd_parser.sv
rtl/dhd_out_stage.sv
rtl/datagram_header_deframer.sv
bench/tb_top.sv
